// ===== rtl/block_average_downsampler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block average downsampler
// Clocked, reset-qualified implication forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_DOWNSAMPLER_TOP_ASSERT_SVH
`define BLOCK_AVERAGE_DOWNSAMPLER_TOP_ASSERT_SVH

// same-cycle implication
`define BAVG_ASSERT_IMPLY(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("bavg assertion failed");

// next-cycle implication
`define BAVG_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("bavg assertion failed");

`endif

// ===== rtl/bavg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared constants and types of the block average downsampler.
// ----------------------------------------------------------------------------
package bavg_pkg;

  localparam int unsigned IMAGE_WIDTH  = 320;
  localparam int unsigned IMAGE_HEIGHT = 240;
  localparam int unsigned BLOCK        = 8;

  localparam int unsigned BLOCK_LOG2 = $clog2(BLOCK);
  localparam int unsigned TILES_X    = IMAGE_WIDTH / BLOCK;
  localparam int unsigned TILES_Y    = IMAGE_HEIGHT / BLOCK;

  localparam int unsigned COL_W = $clog2(IMAGE_WIDTH);
  localparam int unsigned ROW_W = $clog2(IMAGE_HEIGHT);
  localparam int unsigned TX_W  = (TILES_X > 1) ? $clog2(TILES_X) : 1;
  localparam int unsigned TY_W  = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned AVG_W  = 8;
  localparam int unsigned OCOL_W = 6;
  localparam int unsigned OROW_W = 5;
  localparam int unsigned SUM_W  = PIX_W + 2 * BLOCK_LOG2;

  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_FIELDS_W = AVG_W + OCOL_W + OROW_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [TX_W-1:0]  tx;
    logic [TY_W-1:0]  ty;
    logic             clear;
    logic             emit;
    logic             done;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/block_average_downsampler_top.sv =====
// After the pixel beat that completes its tile, the queue, back stage and output register carry its result.
// Throughput: one pixel beat per cycle while the queue is not full; the accumulator memory
// takes one read and one write each cycle, with the newest write forwarded into the add.
// Output back-pressure holds a tile-ending pixel in the back stage; the 2-entry queue
// then fills and stalls the input.
// Reset (rst_ni low, asynchronous): position goes to (0,0), all accumulators read as zero.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_downsampler_top
// Box-filter downsampler: averages each BLOCK x BLOCK tile of a raster frame.
// ----------------------------------------------------------------------------
module block_average_downsampler_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bavg_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // pixel[7:0]
  input  logic                             s_axis_tuser,  // frame_start
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bavg_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // block_average, block_col, block_row
  output logic                             m_axis_tlast   // frame_done
);

  bavg_pkg::item_t   front_item, head_item;
  bavg_pkg::q_stat_t q_stat;
  logic              push, pop;

  bavg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .item_o     (front_item)
  );

  bavg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  bavg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .head_i     (head_item),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

// ===== rtl/bavg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_front
// Tracks raster position, maps each pixel to its tile and flags tile ends.
// ----------------------------------------------------------------------------
module bavg_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [bavg_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  logic                                s_tuser_i,
  input  bavg_pkg::q_stat_t                   q_stat_i,
  output logic                                push_o,
  output bavg_pkg::item_t                     item_o
);

  logic [bavg_pkg::COL_W-1:0] col_q, col_d, cur_col, tx_full;
  logic [bavg_pkg::ROW_W-1:0] row_q, row_d, cur_row, ty_full;
  logic                       accept, in_range, tile_end;

  assign s_tready_o = !q_stat_i.full;
  assign accept     = s_tvalid_i && s_tready_o;

  assign cur_col = s_tuser_i ? '0 : col_q;
  assign cur_row = s_tuser_i ? '0 : row_q;
  assign tx_full = cur_col >> bavg_pkg::BLOCK_LOG2;
  assign ty_full = cur_row >> bavg_pkg::BLOCK_LOG2;

  assign in_range = (tx_full < bavg_pkg::COL_W'(bavg_pkg::TILES_X)) &&
                    (ty_full < bavg_pkg::ROW_W'(bavg_pkg::TILES_Y));
  assign tile_end = (cur_col[bavg_pkg::BLOCK_LOG2-1:0] == '1) &&
                    (cur_row[bavg_pkg::BLOCK_LOG2-1:0] == '1);

  assign push_o = accept && in_range;

  always_comb begin
    item_o.px    = s_tdata_i[bavg_pkg::PIX_W-1:0];
    item_o.tx    = bavg_pkg::TX_W'(tx_full);
    item_o.ty    = bavg_pkg::TY_W'(ty_full);
    item_o.clear = s_tuser_i;
    item_o.emit  = tile_end;
    item_o.done  = tile_end &&
                   (tx_full == bavg_pkg::COL_W'(bavg_pkg::TILES_X - 1)) &&
                   (ty_full == bavg_pkg::ROW_W'(bavg_pkg::TILES_Y - 1));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (cur_col == bavg_pkg::COL_W'(bavg_pkg::IMAGE_WIDTH - 1)) begin
        col_d = '0;
        if (cur_row == bavg_pkg::ROW_W'(bavg_pkg::IMAGE_HEIGHT - 1)) begin
          row_d = '0;
        end else begin
          row_d = cur_row + 1'b1;
        end
      end else begin
        col_d = cur_col + 1'b1;
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/bavg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module bavg_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bavg_pkg::item_t   item_i,
  input  logic              pop_i,
  output bavg_pkg::item_t   head_o,
  output bavg_pkg::q_stat_t stat_o
);

  bavg_pkg::item_t              store_q [bavg_pkg::QUEUE_DEPTH];
  logic [bavg_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bavg_pkg::QPTR_W:0]    count_q, count_d;

  assign stat_o.full  = (count_q == (bavg_pkg::QPTR_W+1)'(bavg_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = store_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bavg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_back
// Column accumulator memory, read-modify-write stage and output register.
// ----------------------------------------------------------------------------
module bavg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bavg_pkg::q_stat_t                 q_stat_i,
  input  bavg_pkg::item_t                   head_i,
  output logic                              pop_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [bavg_pkg::M_TDATA_W-1:0]    m_tdata_o,
  output logic                              m_tlast_o
);

  logic [bavg_pkg::SUM_W-1:0] acc_mem [bavg_pkg::TILES_X];
  logic [bavg_pkg::SUM_W-1:0] rd_q;

  bavg_pkg::item_t            s1_q;
  logic                       s1_valid_q, s1_valid_d, s1_fire;

  logic [bavg_pkg::TILES_X-1:0] vld_q, vld_d;
  logic                         fw_valid_q;
  logic [bavg_pkg::TX_W-1:0]    fw_tx_q;
  logic [bavg_pkg::SUM_W-1:0]   fw_data_q;

  logic [bavg_pkg::SUM_W-1:0] base, sum, wr_data;

  logic                               m_valid_q;
  logic [bavg_pkg::M_FIELDS_W-1:0]    m_data_q;
  logic                               m_last_q;

  assign s1_fire = s1_valid_q && (!s1_q.emit || !m_valid_q || m_tready_i);
  assign pop_o   = !q_stat_i.empty && (!s1_valid_q || s1_fire);

  // newest write wins; a frame start sees empty accumulators
  always_comb begin
    priority if (s1_q.clear) begin
      base = '0;
    end else if (fw_valid_q && (fw_tx_q == s1_q.tx)) begin
      base = fw_data_q;
    end else if (vld_q[s1_q.tx]) begin
      base = rd_q;
    end else begin
      base = '0;
    end
  end

  assign sum     = base + bavg_pkg::SUM_W'(s1_q.px);
  assign wr_data = s1_q.emit ? '0 : sum;

  always_comb begin
    vld_d = vld_q;
    if (s1_fire) begin
      if (s1_q.clear) begin
        vld_d = '0;
      end
      vld_d[s1_q.tx] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q <= acc_mem[head_i.tx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      acc_mem[s1_q.tx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= head_i;
    end
    if (s1_fire) begin
      fw_tx_q   <= s1_q.tx;
      fw_data_q <= wr_data;
    end
    if (s1_fire && s1_q.emit) begin
      m_data_q <= {bavg_pkg::OROW_W'(s1_q.ty),
                   bavg_pkg::OCOL_W'(s1_q.tx),
                   bavg_pkg::AVG_W'(sum >> (2 * bavg_pkg::BLOCK_LOG2))};
      m_last_q <= s1_q.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      vld_q      <= '0;
      fw_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      vld_q      <= vld_d;
      if (s1_fire) begin
        fw_valid_q <= 1'b1;
      end
      if (s1_fire && s1_q.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = bavg_pkg::M_TDATA_W'(m_data_q);
  assign m_tlast_o  = m_last_q;

endmodule

// ===== rtl/bavg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_checker
// Port-level checks on the downsampler's result stream.
// ----------------------------------------------------------------------------
`include "block_average_downsampler_top_assert.svh"

module bavg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bavg_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic                             m_axis_tlast
);

  localparam int unsigned ColLo = bavg_pkg::AVG_W;
  localparam int unsigned RowLo = bavg_pkg::AVG_W + bavg_pkg::OCOL_W;

  logic [bavg_pkg::OCOL_W-1:0]  beat_col;
  logic [bavg_pkg::OROW_W-1:0]  beat_row;
  logic                         pad_zero;
  logic                         out_stall;
  logic                         last_tile;
  logic [bavg_pkg::M_TDATA_W:0] out_beat;

  assign beat_col  = m_axis_tdata[ColLo +: bavg_pkg::OCOL_W];
  assign beat_row  = m_axis_tdata[RowLo +: bavg_pkg::OROW_W];
  assign pad_zero  = (m_axis_tdata >> bavg_pkg::M_FIELDS_W) == '0;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_beat  = {m_axis_tlast, m_axis_tdata};
  assign last_tile = (beat_col == bavg_pkg::OCOL_W'(bavg_pkg::TILES_X - 1)) &&
                     (beat_row == bavg_pkg::OROW_W'(bavg_pkg::TILES_Y - 1));

  `BAVG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid)
  `BAVG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_beat))
  `BAVG_ASSERT_IMPLY(a_last_tile, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, last_tile)
  `BAVG_ASSERT_IMPLY(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, pad_zero)

endmodule

bind block_average_downsampler_top bavg_checker u_bavg_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block average downsampler. Pixel beats are
// streamed in raster order with random gaps on both sides. Each accepted beat
// is fed to a tile-sum predictor. Each output beat is compared field by field
// with the oldest predicted tile average.
// ----------------------------------------------------------------------------
module tb_top;
  import bavg_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned CYCLE_LIMIT   = 100_000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SPLIT_A       = 12 * BLOCK;
  localparam int unsigned SPLIT_B       = 24 * BLOCK;

  typedef enum {PAT_RANDOM, PAT_BANDS} pixel_pattern_e;

  typedef struct packed {
    logic [AVG_W-1:0]  avg;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              last;
  } tile_result_t;

  class tile_scoreboard;
    bit [SUM_W-1:0] col_acc [TILES_X];
    bit [COL_W-1:0] cur_col;
    bit [ROW_W-1:0] cur_row;
    tile_result_t   tiles_due [$];
    int unsigned    pixels;
    int unsigned    tiles_predicted;
    int unsigned    tiles_seen;
    int unsigned    frames_closed;
    int unsigned    errors;

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void note_pixel(bit [PIX_W-1:0] px, bit frame_start);
      int unsigned  tx;
      int unsigned  ty;
      tile_result_t r;
      pixels++;
      if (frame_start) begin
        col_acc = '{default: '0};
        cur_col = '0;
        cur_row = '0;
      end
      tx = cur_col >> BLOCK_LOG2;
      ty = cur_row >> BLOCK_LOG2;
      if (tx < TILES_X && ty < TILES_Y) begin
        col_acc[tx] += px;
        if (cur_col % BLOCK == BLOCK - 1 && cur_row % BLOCK == BLOCK - 1) begin
          r.avg  = AVG_W'(col_acc[tx] >> (2 * BLOCK_LOG2));
          r.col  = OCOL_W'(tx);
          r.row  = OROW_W'(ty);
          r.last = (tx == TILES_X - 1) && (ty == TILES_Y - 1);
          tiles_due.push_back(r);
          tiles_predicted++;
          col_acc[tx] = '0;
        end
      end
      if (cur_col == IMAGE_WIDTH - 1) begin
        cur_col = '0;
        cur_row = (cur_row == IMAGE_HEIGHT - 1) ? '0 : cur_row + 1'b1;
      end else begin
        cur_col++;
      end
    endfunction

    function void check_tile(tile_result_t got);
      tile_result_t want;
      tiles_seen++;
      if (got.last) frames_closed++;
      if (tiles_due.size() == 0) begin
        report($sformatf("tile beat (avg %0d col %0d row %0d) with none predicted",
                         got.avg, got.col, got.row));
        return;
      end
      want = tiles_due.pop_front();
      if (got.avg !== want.avg)
        report($sformatf("block_average expected %0d, got %0d", want.avg, got.avg));
      if (got.col !== want.col)
        report($sformatf("block_col expected %0d, got %0d", want.col, got.col));
      if (got.row !== want.row)
        report($sformatf("block_row expected %0d, got %0d", want.row, got.row));
      if (got.last !== want.last)
        report($sformatf("frame_done expected %0d, got %0d", want.last, got.last));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // pixel[7:0]
  logic                 s_axis_tuser;   // frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // block_average, block_col, block_row
  logic                 m_axis_tlast;   // frame_done

  tile_scoreboard sb;
  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;
  int unsigned    hold_reqs;

  block_average_downsampler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d tiles outstanding",
             CYCLE_LIMIT, sb.tiles_due.size());
    $display("FAILURE");
    $finish;
  end

  // receiver: random back-pressure plus requested long holds
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left     = 0;
    holds_done    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    tile_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.avg  = m_axis_tdata[AVG_W-1:0];
      got.col  = m_axis_tdata[AVG_W +: OCOL_W];
      got.row  = m_axis_tdata[AVG_W+OCOL_W +: OROW_W];
      got.last = m_axis_tlast;
      sb.check_tile(got);
    end
  end

  // called and returns at a falling edge
  task automatic send_pixel(input bit [PIX_W-1:0] px, input bit frame_start);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= frame_start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(px, frame_start);
    @(negedge clk_i);
  endtask

  // bands follow the tile column: random, full white, black, near white
  task automatic send_run(input int unsigned n, input bit start_first,
                          input pixel_pattern_e pat);
    int unsigned    band;
    bit [PIX_W-1:0] px;
    for (int unsigned i = 0; i < n; i++) begin
      band = (sb.cur_col >> BLOCK_LOG2) % 4;
      px   = PIX_W'($urandom_range(255));
      if (pat == PAT_BANDS) begin
        case (band)
          1: px = 8'hFF;
          2: px = 8'h00;
          3: px = PIX_W'($urandom_range(255, 240));
          default: ;
        endcase
      end
      send_pixel(px, start_first && i == 0);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.tiles_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    sb            = new;
    tx_idle_pct   = 19;
    rx_idle_pct   = 52;
    hold_reqs     = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // pixel extremes, back-to-back and mid-row frame starts
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h01, 1'b1);
    send_pixel(8'hFE, 1'b1);
    send_pixel(8'h7F, 1'b0);
    send_pixel(8'h00, 1'b0);

    // partial sums that the next frame start has to clear
    send_run(IMAGE_WIDTH / 4, 1'b1, PAT_RANDOM);

    // first band of tiles; its bottom row emits the averages
    send_run((BLOCK - 1) * IMAGE_WIDTH + SPLIT_A, 1'b1, PAT_BANDS);
    tx_idle_pct = 52;
    rx_idle_pct = 19;
    send_run(SPLIT_B - SPLIT_A, 1'b0, PAT_BANDS);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // long output stall across the remaining tile-ending beats
    hold_reqs++;
    send_run(IMAGE_WIDTH - SPLIT_B, 1'b0, PAT_BANDS);
    drain();

    $display("%0d pixel beats in, %0d tile averages checked, %0d frames closed, %0d errors",
             sb.pixels, sb.tiles_seen, sb.frames_closed, sb.errors);
    $display("ran frame restarts, a full band of tiles under both gap mixes and a held-off output");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
